// ----- hdl/ctlt_pkg.sv -----
// Shared constants, register codes and types of the current limited throttle.
`default_nettype none
package ctlt_pkg;

  localparam int AVG_DEPTH = 8;
  localparam int RING_IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int PCT_W = 7;
  localparam int RING_SUM_W = $clog2(100 * AVG_DEPTH + 1);

  localparam int OP_W = 2;
  localparam int BYTE_W = 8;
  localparam int SAMPLE_W = 16;
  localparam int CODE_W = 12;
  localparam int DUTY_W = 15;
  localparam int STATUS_W = 3;
  localparam int LIMIT_W = 15;
  localparam int MS_W = 17;
  localparam int TIMEOUT_W = 16;
  localparam int ALPHA_W = 9;
  localparam int FILT_W = 24;
  localparam int QLIM_W = LIMIT_W + 8;

  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_THROTTLE = 2'd1;
  localparam logic [OP_W-1:0] OP_CURRENT = 2'd2;

  localparam logic [STATUS_W-1:0] LIM_FULL = 3'd0;
  localparam logic [STATUS_W-1:0] LIM_SCALED = 3'd1;
  localparam logic [STATUS_W-1:0] LIM_NO_CURRENT = 3'd2;
  localparam logic [STATUS_W-1:0] LIM_STALE = 3'd3;
  localparam logic [STATUS_W-1:0] LIM_HARD_TRIP = 3'd4;

  localparam logic [DUTY_W-1:0] FULL_DUTY = 15'd25600;
  localparam logic [MS_W-1:0] MS_SAT = '1;
  localparam logic [CODE_W:0] NONE_WRITTEN = '1;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
  localparam logic [BYTE_W-1:0] THROTTLE_FULL = 8'd255;
  localparam int PCT_SCALE = 100;

  // shared serial divider: quotient always fits DIV_QUO_W bits
  localparam int DIV_SOR_W = QLIM_W;
  localparam int DIV_QUO_W = 15;
  localparam int DIV_DEND_W = DIV_SOR_W + DIV_QUO_W;
  localparam int DIV_CNT_W = $clog2(DIV_QUO_W + 1);

  // shared multiplier
  localparam int MUL_A_W = 15;
  localparam int MUL_B_W = 26;
  localparam int MUL_P_W = MUL_A_W + 1 + MUL_B_W;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_SOFT_LIMIT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HARD_LIMIT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CUR_TIMEOUT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STALE_TIME = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FILTER_ALPHA = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SMOOTH_EN = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DAC_MAX = 3'd6;

  localparam logic [LIMIT_W-1:0] SOFT_LIMIT_RST = 15'd1000;
  localparam logic [LIMIT_W-1:0] HARD_LIMIT_RST = 15'd1500;
  localparam logic [TIMEOUT_W-1:0] CUR_TIMEOUT_RST = 16'd500;
  localparam logic [TIMEOUT_W-1:0] STALE_TIME_RST = 16'd500;
  localparam logic [ALPHA_W-1:0] FILTER_ALPHA_RST = 9'd26;
  localparam logic [CODE_W-1:0] DAC_MAX_RST = 12'd4095;

  typedef struct packed {
    logic [LIMIT_W-1:0] soft_limit;
    logic [LIMIT_W-1:0] hard_limit;
    logic [TIMEOUT_W-1:0] cur_timeout;
    logic [TIMEOUT_W-1:0] stale_time_ms;
    logic [ALPHA_W-1:0] filter_alpha;
    logic smooth_enable;
    logic [CODE_W-1:0] dac_max;
  } ctlt_cfg_t;

endpackage
`default_nettype wire

// ----- hdl/ctlt_if.sv -----
// Request and result channel interfaces of the current limited throttle.
`default_nettype none
interface ctlt_in_if;
  import ctlt_pkg::*;
  logic valid;
  logic ready;
  logic [OP_W-1:0] operation;
  logic [BYTE_W-1:0] throttle_byte;
  logic signed [SAMPLE_W-1:0] current_sample;

  modport source (output valid, operation, throttle_byte, current_sample, input ready);
  modport sink (input valid, operation, throttle_byte, current_sample, output ready);
endinterface

interface ctlt_out_if;
  import ctlt_pkg::*;
  logic valid;
  logic ready;
  logic [CODE_W-1:0] dac_code;
  logic dac_write;
  logic [DUTY_W-1:0] applied_duty;
  logic [STATUS_W-1:0] limit_status;

  modport source (output valid, dac_code, dac_write, applied_duty, limit_status, input ready);
  modport sink (input valid, dac_code, dac_write, applied_duty, limit_status, output ready);
endinterface
`default_nettype wire

// ----- hdl/ctlt_cfg.sv -----
// APB configuration registers of the current limited throttle.
`default_nettype none
module ctlt_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ctlt_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [ctlt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [ctlt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready,
  output ctlt_pkg::ctlt_cfg_t                 cfg
);
  import ctlt_pkg::*;

  ctlt_cfg_t cfg_r;
  logic [REG_IDX_W-1:0] idx;
  logic wr_en;

  assign idx = paddr[CFG_ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.soft_limit <= SOFT_LIMIT_RST;
      cfg_r.hard_limit <= HARD_LIMIT_RST;
      cfg_r.cur_timeout <= CUR_TIMEOUT_RST;
      cfg_r.stale_time_ms <= STALE_TIME_RST;
      cfg_r.filter_alpha <= FILTER_ALPHA_RST;
      cfg_r.smooth_enable <= 1'b1;
      cfg_r.dac_max <= DAC_MAX_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SOFT_LIMIT:   cfg_r.soft_limit <= pwdata[LIMIT_W-1:0];
        REG_HARD_LIMIT:   cfg_r.hard_limit <= pwdata[LIMIT_W-1:0];
        REG_CUR_TIMEOUT:  cfg_r.cur_timeout <= pwdata[TIMEOUT_W-1:0];
        REG_STALE_TIME:   cfg_r.stale_time_ms <= pwdata[TIMEOUT_W-1:0];
        REG_FILTER_ALPHA: cfg_r.filter_alpha <= pwdata[ALPHA_W-1:0];
        REG_SMOOTH_EN:    cfg_r.smooth_enable <= pwdata[0];
        REG_DAC_MAX:      cfg_r.dac_max <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SOFT_LIMIT:   prdata = CFG_DATA_W'(cfg_r.soft_limit);
      REG_HARD_LIMIT:   prdata = CFG_DATA_W'(cfg_r.hard_limit);
      REG_CUR_TIMEOUT:  prdata = CFG_DATA_W'(cfg_r.cur_timeout);
      REG_STALE_TIME:   prdata = CFG_DATA_W'(cfg_r.stale_time_ms);
      REG_FILTER_ALPHA: prdata = CFG_DATA_W'(cfg_r.filter_alpha);
      REG_SMOOTH_EN:    prdata = CFG_DATA_W'(cfg_r.smooth_enable);
      REG_DAC_MAX:      prdata = CFG_DATA_W'(cfg_r.dac_max);
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/ctlt_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module ctlt_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [ctlt_pkg::DIV_DEND_W-1:0] dividend,
  input  wire logic [ctlt_pkg::DIV_SOR_W-1:0]  divisor,
  output logic                                done,
  output logic      [ctlt_pkg::DIV_QUO_W-1:0]  quotient
);
  import ctlt_pkg::*;

  logic [DIV_SOR_W-1:0] rem_r, rem_nxt, dsr_r;
  logic [DIV_QUO_W-1:0] quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic busy_r, done_r;
  logic [DIV_SOR_W:0] trial;

  assign done = done_r;
  assign quotient = quo_r;

  always_comb begin
    trial = {rem_r, quo_r[DIV_QUO_W-1]};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = DIV_SOR_W'(trial - {1'b0, dsr_r});
      quo_nxt = {quo_r[DIV_QUO_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DIV_SOR_W-1:0];
      quo_nxt = {quo_r[DIV_QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= dividend[DIV_DEND_W-1:DIV_QUO_W];
        quo_r <= dividend[DIV_QUO_W-1:0];
        dsr_r <= divisor;
        cnt_r <= DIV_CNT_W'(DIV_QUO_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/current_limited_throttle_unit.sv -----
// Top level: sequencer, state and shared multiplier of the current limited throttle.
//
// Requests arrive on in_if: operation 0 is a 1 ms tick, 1 a throttle byte, 2 a
// pack current sample in 0.1 A; operation 3 only re-reports the present state.
// Every request yields exactly one result on out_if: the DAC code, a flag that
// the code changed since the last one written, the protected duty in Q7.8
// percent and the limit status. Registers are to be written over the APB port
// only while the block is idle; the block itself does not enforce this.
// One request is in flight at a time; in_if.ready is high only between
// requests. The next request can be taken in the cycle after its result is
// loaded. The work is set by the 15-step serial divider, with a start state
// and a wait for the quotient around it, used one to four times per request;
// each use but the ring average has a multiply step ahead.
// A finished result sits in an output register; the next request is taken
// while it waits, and only its own result waits for out_if.ready.
// Synchronous reset clears the ring, the filter, the counters and the
// registers to their defaults; the last DAC code reads as none written.
`default_nettype none
module current_limited_throttle_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  ctlt_in_if.sink                             in_if,
  ctlt_out_if.source                          out_if,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ctlt_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [ctlt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [ctlt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready
);
  import ctlt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_EMA_ADD, ST_DIV, ST_WAIT, ST_STALE, ST_PROT, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    DU_PCT, DU_AVG, DU_DIR, DU_EMA, DU_SCALE, DU_DAC
  } use_t;

  ctlt_cfg_t cfg;
  state_t state_r;
  use_t use_r;

  logic [BYTE_W-1:0] byte_r;
  logic [PCT_W-1:0] ring_r [AVG_DEPTH];
  logic [RING_IDX_W-1:0] ring_pos_r;
  logic [RING_SUM_W-1:0] ring_sum_r;
  logic [DUTY_W-1:0] requested_r, duty_r;
  logic signed [SAMPLE_W-1:0] raw_r;
  logic signed [FILT_W-1:0] filt_r;
  logic seen_r;
  logic [MS_W-1:0] ms_thr_r, ms_cur_r;
  logic [CODE_W:0] last_code_r;
  logic [CODE_W-1:0] code_r;
  logic [STATUS_W-1:0] status_r;
  logic [QLIM_W-1:0] num_r;
  logic signed [MUL_P_W-1:0] prod_r;

  logic out_valid_r;
  logic [CODE_W-1:0] out_code_r;
  logic out_write_r;
  logic [DUTY_W-1:0] out_duty_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [FILT_W:0] diff;
  logic [ALPHA_W-1:0] alpha_sat;
  logic [DUTY_W-1:0] duty_clamp;
  logic div_start, div_done;
  logic [DIV_DEND_W-1:0] div_dend;
  logic [DIV_SOR_W-1:0] div_sor;
  logic [DIV_QUO_W-1:0] div_quo;
  logic [LIMIT_W-1:0] raw_pos;
  logic [QLIM_W-1:0] filt_pos, hard_q, soft_q;
  logic [LIMIT_W-1:0] span;
  logic [PCT_W:0] pct_ext;
  logic [RING_SUM_W-1:0] sum_nxt;
  logic out_free, in_acc;

  ctlt_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  ctlt_div u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_dend), .divisor(div_sor),
    .done(div_done), .quotient(div_quo)
  );

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc = in_if.valid && (state_r == ST_IDLE);
  assign out_if.valid = out_valid_r;
  assign out_if.dac_code = out_code_r;
  assign out_if.dac_write = out_write_r;
  assign out_if.applied_duty = out_duty_r;
  assign out_if.limit_status = out_status_r;
  assign out_free = !out_valid_r || out_if.ready;

  assign alpha_sat = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
  assign diff = {raw_r[SAMPLE_W-1], raw_r, 8'h00} - {filt_r[FILT_W-1], filt_r};
  assign duty_clamp = (duty_r > FULL_DUTY) ? FULL_DUTY : duty_r;
  assign raw_pos = raw_r[SAMPLE_W-1] ? '0 : raw_r[LIMIT_W-1:0];
  assign filt_pos = filt_r[FILT_W-1] ? '0 : filt_r[QLIM_W-1:0];
  assign hard_q = {cfg.hard_limit, 8'h00};
  assign soft_q = {cfg.soft_limit, 8'h00};
  assign span = cfg.hard_limit - cfg.soft_limit;
  assign pct_ext = {1'b0, div_quo[PCT_W-1:0]};
  assign sum_nxt = ring_sum_r - RING_SUM_W'(ring_r[ring_pos_r]) + RING_SUM_W'(pct_ext);
  assign div_start = (state_r == ST_DIV);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (use_r)
      DU_PCT: begin
        mul_a = MUL_A_W'(byte_r);
        mul_b = MUL_B_W'(PCT_SCALE);
      end
      DU_DIR: begin
        mul_a = MUL_A_W'(byte_r);
        mul_b = $signed(MUL_B_W'(FULL_DUTY));
      end
      DU_EMA: begin
        mul_a = MUL_A_W'(alpha_sat);
        mul_b = MUL_B_W'(diff);
      end
      DU_SCALE: begin
        mul_a = requested_r;
        mul_b = $signed(MUL_B_W'(num_r));
      end
      DU_DAC: begin
        mul_a = duty_clamp;
        mul_b = $signed(MUL_B_W'(cfg.dac_max));
      end
      default: ;
    endcase
  end

  always_comb begin
    div_dend = (use_r == DU_AVG) ? DIV_DEND_W'(ring_sum_r) : prod_r[DIV_DEND_W-1:0];
    unique case (use_r)
      DU_PCT, DU_DIR: div_sor = DIV_SOR_W'(THROTTLE_FULL);
      DU_SCALE:       div_sor = {span, 8'h00};
      DU_DAC:         div_sor = DIV_SOR_W'(FULL_DUTY);
      default:        div_sor = DIV_SOR_W'(AVG_DEPTH);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      use_r <= DU_DAC;
      for (int i = 0; i < AVG_DEPTH; i++) ring_r[i] <= '0;
      ring_pos_r <= '0;
      ring_sum_r <= '0;
      requested_r <= '0;
      raw_r <= '0;
      filt_r <= '0;
      seen_r <= 1'b0;
      ms_thr_r <= '0;
      ms_cur_r <= '0;
      last_code_r <= NONE_WRITTEN;
      out_valid_r <= 1'b0;
    end else begin
      if (out_if.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            byte_r <= in_if.throttle_byte;
            state_r <= ST_STALE;
            if (in_if.operation == OP_TICK) begin
              if (ms_thr_r != MS_SAT) ms_thr_r <= ms_thr_r + 1'b1;
              if (ms_cur_r != MS_SAT) ms_cur_r <= ms_cur_r + 1'b1;
            end else if (in_if.operation == OP_THROTTLE) begin
              ms_thr_r <= '0;
              use_r <= cfg.smooth_enable ? DU_PCT : DU_DIR;
              state_r <= ST_MUL;
            end else if (in_if.operation == OP_CURRENT) begin
              raw_r <= in_if.current_sample;
              ms_cur_r <= '0;
              seen_r <= 1'b1;
              if (!seen_r) begin
                filt_r <= {in_if.current_sample, 8'h00};
              end else begin
                use_r <= DU_EMA;
                state_r <= ST_MUL;
              end
            end
          end
        end
        ST_MUL: begin
          prod_r <= $signed({1'b0, mul_a}) * mul_b;
          state_r <= (use_r == DU_EMA) ? ST_EMA_ADD : ST_DIV;
        end
        ST_EMA_ADD: begin
          filt_r <= filt_r + prod_r[FILT_W+7:8];
          state_r <= ST_STALE;
        end
        ST_DIV: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_done) begin
            unique case (use_r)
              DU_PCT: begin
                ring_r[ring_pos_r] <= div_quo[PCT_W-1:0];
                ring_sum_r <= sum_nxt;
                ring_pos_r <= (ring_pos_r == RING_IDX_W'(AVG_DEPTH - 1)) ? '0
                              : ring_pos_r + 1'b1;
                use_r <= DU_AVG;
                state_r <= ST_DIV;
              end
              DU_AVG: begin
                requested_r <= {div_quo[PCT_W-1:0], 8'h00};
                state_r <= ST_STALE;
              end
              DU_DIR: begin
                requested_r <= div_quo;
                state_r <= ST_STALE;
              end
              DU_SCALE: begin
                duty_r <= div_quo;
                use_r <= DU_DAC;
                state_r <= ST_MUL;
              end
              default: begin
                code_r <= div_quo[CODE_W-1:0];
                state_r <= ST_OUT;
              end
            endcase
          end
        end
        ST_STALE: begin
          if (requested_r != '0 && ms_thr_r > MS_W'(cfg.stale_time_ms)) requested_r <= '0;
          state_r <= ST_PROT;
        end
        ST_PROT: begin
          use_r <= DU_DAC;
          state_r <= ST_MUL;
          duty_r <= '0;
          priority if (!seen_r) begin
            status_r <= LIM_NO_CURRENT;
          end else if (ms_cur_r > MS_W'(cfg.cur_timeout)) begin
            status_r <= LIM_STALE;
          end else if (raw_pos >= cfg.hard_limit) begin
            status_r <= LIM_HARD_TRIP;
          end else if (filt_pos <= soft_q) begin
            status_r <= LIM_FULL;
            duty_r <= requested_r;
          end else begin
            status_r <= LIM_SCALED;
            if (cfg.hard_limit > cfg.soft_limit && filt_pos < hard_q) begin
              num_r <= hard_q - filt_pos;
              use_r <= DU_SCALE;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_code_r <= code_r;
            out_duty_r <= duty_clamp;
            out_status_r <= status_r;
            out_write_r <= ({1'b0, code_r} != last_code_r);
            if ({1'b0, code_r} != last_code_r) last_code_r <= {1'b0, code_r};
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("request taken while a request is in flight");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.applied_duty <= FULL_DUTY))
    else $error("applied duty above full scale");

  a_cut_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && (out_if.limit_status == LIM_NO_CURRENT ||
     out_if.limit_status == LIM_STALE || out_if.limit_status == LIM_HARD_TRIP))
    |-> (out_if.applied_duty == '0 && out_if.dac_code == '0))
    else $error("nonzero duty under a cut status");

  a_code_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.dac_write) |-> (last_code_r == {1'b0, out_if.dac_code}))
    else $error("last written code not updated");
`endif

endmodule
`default_nettype wire
